>>> src/stsc_pkg.sv
// Shared types, character codes and classification functions of the source token scanner.
package stsc_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int LENGTH_BITS_DEF   = 8;
  localparam int FIFO_DEPTH        = 4;

  typedef enum logic [3:0] {
    K_SEGMENT  = 4'd0,
    K_TYPE     = 4'd1,
    K_IDENT    = 4'd2,
    K_LPAREN   = 4'd3,
    K_RPAREN   = 4'd4,
    K_COMMA    = 4'd5,
    K_OPERATOR = 4'd6,
    K_KEYWORD  = 4'd7,
    K_INTEGER  = 4'd8,
    K_UNKNOWN  = 4'd9,
    K_NONE     = 4'd10
  } token_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NAME   = 2'd1,
    MODE_NUMBER = 2'd2
  } scan_mode_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;

  // Leading name bytes are packed first byte lowest.
  localparam logic [23:0] W_I1  = {8'h00, "1", "i"};
  localparam logic [23:0] W_I2  = {8'h00, "2", "i"};
  localparam logic [23:0] W_I4  = {8'h00, "4", "i"};
  localparam logic [23:0] W_I8  = {8'h00, "8", "i"};
  localparam logic [23:0] W_U1  = {8'h00, "1", "u"};
  localparam logic [23:0] W_U2  = {8'h00, "2", "u"};
  localparam logic [23:0] W_U4  = {8'h00, "4", "u"};
  localparam logic [23:0] W_U8  = {8'h00, "8", "u"};
  localparam logic [23:0] W_PTR = {"r", "t", "p"};
  localparam logic [23:0] W_RET = {"t", "e", "r"};
  localparam logic [23:0] W_END = {"d", "n", "e"};

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF};
  endfunction

  function automatic token_kind_t name_kind(input logic [23:0] chars);
    token_kind_t k;
    case (chars)
      W_I1, W_I2, W_I4, W_I8, W_U1, W_U2, W_U4, W_U8, W_PTR: k = K_TYPE;
      W_RET, W_END: k = K_KEYWORD;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

  // Keeps up to three name bytes; goes to zero once the name grows longer.
  function automatic logic [23:0] add_leading(input logic [23:0] chars, input logic [7:0] c);
    logic [23:0] r;
    r = chars;
    if (chars != '0) begin
      if (chars[23:16] != 8'h00) begin
        r = '0;
      end else if (chars[15:8] != 8'h00) begin
        r[23:16] = c;
      end else begin
        r[15:8] = c;
      end
    end
    return r;
  endfunction

  function automatic token_kind_t punct_kind(input logic [7:0] c);
    token_kind_t k;
    case (c)
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_COMMA:  k = K_COMMA;
      CH_EQUAL, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: k = K_OPERATOR;
      default:   k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] punct_prec(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      CH_PLUS, CH_MINUS: p = 2'd1;
      CH_STAR, CH_SLASH: p = 2'd2;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

>>> src/stsc_if.sv
// Byte and token stream interfaces of the source token scanner.
interface stsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface stsc_token_if import stsc_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [3:0]               token_kind;
  logic [POSITION_BITS-1:0] token_start;
  logic [LENGTH_BITS-1:0]   token_length;
  logic [1:0]               op_precedence;
  logic                     statement_last;
  logic                     source_end;
  logic                     run_last;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output op_precedence, output statement_last, output source_end,
                  output run_last, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_length,
                input op_precedence, input statement_last, input source_end,
                input run_last, output ready);
endinterface

>>> src/stsc_scan_core.sv
// Scanner state and per-byte token decision, producing up to two packed results.
module stsc_scan_core import stsc_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               take,
  input  logic [7:0]                         source_byte,
  output logic [1:0]                         push_count,
  output logic [POSITION_BITS+LENGTH_BITS+8:0] slot0,
  output logic [POSITION_BITS+LENGTH_BITS+8:0] slot1
);

  localparam int RES_W = POSITION_BITS + LENGTH_BITS + 9;

  logic [POSITION_BITS-1:0] position, position_next;
  scan_mode_t               mode, mode_next;
  logic [POSITION_BITS-1:0] scan_start, start_next;
  logic [LENGTH_BITS-1:0]   scan_length, length_next;
  logic [23:0]              leading, leading_next;
  logic                     held_valid, held_valid_next;
  token_kind_t              held_kind, held_kind_next;
  logic [POSITION_BITS-1:0] held_start, held_start_next;
  logic [LENGTH_BITS-1:0]   held_length, held_length_next;
  logic [1:0]               held_prec, held_prec_next;
  logic                     statement_open, open_next;
  logic                     source_done, done_next;
  logic                     letter, digit, consumed;

  // Layout from the top: kind, start, length, precedence, last, end, run_last.
  function automatic logic [RES_W-1:0] pack(input token_kind_t k,
                                            input logic [POSITION_BITS-1:0] s,
                                            input logic [LENGTH_BITS-1:0] l,
                                            input logic [1:0] p,
                                            input logic last,
                                            input logic fin);
    return {k, s, l, p, last, fin, 1'b0};
  endfunction

  assign letter = is_letter(source_byte);
  assign digit  = is_digit(source_byte);

  always_comb begin
    position_next    = position;
    mode_next        = mode;
    start_next       = scan_start;
    length_next      = scan_length;
    leading_next     = leading;
    held_valid_next  = held_valid;
    held_kind_next   = held_kind;
    held_start_next  = held_start;
    held_length_next = held_length;
    held_prec_next   = held_prec;
    open_next        = statement_open;
    done_next        = source_done;
    slot0            = '0;
    slot1            = '0;
    push_count       = 2'd0;
    consumed         = 1'b0;
    if (take && !source_done) begin
      position_next = position + 1'b1;
      if (mode == MODE_NAME) begin
        if (letter || digit) begin
          length_next  = (scan_length == '1) ? scan_length : scan_length + 1'b1;
          leading_next = add_leading(leading, source_byte);
          consumed     = 1'b1;
        end else if (source_byte == CH_COLON) begin
          slot0      = pack(K_SEGMENT, scan_start, scan_length, 2'd0, 1'b1, 1'b0);
          push_count = 2'd1;
          mode_next  = MODE_IDLE;
          open_next  = 1'b0;
          consumed   = 1'b1;
        end else begin
          held_valid_next  = 1'b1;
          held_kind_next   = name_kind(leading);
          held_start_next  = scan_start;
          held_length_next = scan_length;
          held_prec_next   = 2'd0;
          mode_next        = MODE_IDLE;
        end
      end else if (mode == MODE_NUMBER) begin
        if (digit) begin
          length_next = (scan_length == '1) ? scan_length : scan_length + 1'b1;
          consumed    = 1'b1;
        end else begin
          held_valid_next  = 1'b1;
          held_kind_next   = K_INTEGER;
          held_start_next  = scan_start;
          held_length_next = scan_length;
          held_prec_next   = 2'd0;
          mode_next        = MODE_IDLE;
        end
      end

      if (!consumed && !is_space(source_byte)) begin
        if (source_byte == CH_NUL) begin
          if (held_valid_next) begin
            slot0      = pack(held_kind_next, held_start_next, held_length_next,
                              held_prec_next, 1'b1, 1'b0);
            slot1      = pack(K_NONE, position, '0, 2'd0, 1'b0, 1'b1);
            push_count = 2'd2;
          end else begin
            slot0      = pack(K_NONE, position, '0, 2'd0, 1'b0, 1'b1);
            push_count = 2'd1;
          end
          held_valid_next = 1'b0;
          open_next       = 1'b0;
          done_next       = 1'b1;
        end else if (source_byte == CH_SEMI) begin
          if (held_valid_next) begin
            slot0           = pack(held_kind_next, held_start_next, held_length_next,
                                   held_prec_next, 1'b1, 1'b0);
            push_count      = 2'd1;
            held_valid_next = 1'b0;
          end else if (!statement_open) begin
            slot0      = pack(K_NONE, position, '0, 2'd0, 1'b0, 1'b1);
            push_count = 2'd1;
            done_next  = 1'b1;
          end
          open_next = 1'b0;
        end else if (letter || digit) begin
          if (held_valid_next) begin
            slot0      = pack(held_kind_next, held_start_next, held_length_next,
                              held_prec_next, 1'b0, 1'b0);
            push_count = 2'd1;
          end
          held_valid_next = 1'b0;
          mode_next       = letter ? MODE_NAME : MODE_NUMBER;
          start_next      = position;
          length_next     = LENGTH_BITS'(1);
          leading_next    = letter ? {16'h0000, source_byte} : 24'h000000;
          open_next       = 1'b1;
        end else begin
          if (held_valid_next) begin
            slot0      = pack(held_kind_next, held_start_next, held_length_next,
                              held_prec_next, 1'b0, 1'b0);
            push_count = 2'd1;
          end
          held_valid_next  = 1'b1;
          held_kind_next   = punct_kind(source_byte);
          held_start_next  = position;
          held_length_next = LENGTH_BITS'(1);
          held_prec_next   = punct_prec(source_byte);
          open_next        = 1'b1;
        end
      end

      if (push_count == 2'd2) begin
        slot1[0] = 1'b1;
      end else if (push_count == 2'd1) begin
        slot0[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      mode           <= MODE_IDLE;
      scan_start     <= '0;
      scan_length    <= '0;
      leading        <= '0;
      held_valid     <= 1'b0;
      held_kind      <= K_SEGMENT;
      held_start     <= '0;
      held_length    <= '0;
      held_prec      <= 2'd0;
      statement_open <= 1'b0;
      source_done    <= 1'b0;
    end else begin
      position       <= position_next;
      mode           <= mode_next;
      scan_start     <= start_next;
      scan_length    <= length_next;
      leading        <= leading_next;
      held_valid     <= held_valid_next;
      held_kind      <= held_kind_next;
      held_start     <= held_start_next;
      held_length    <= held_length_next;
      held_prec      <= held_prec_next;
      statement_open <= open_next;
      source_done    <= done_next;
    end
  end

endmodule

>>> src/stsc_result_fifo.sv
// Small result queue: up to two results in a cycle, one out a cycle if rd_ready.
module stsc_result_fifo import stsc_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_count,
  input  logic [WIDTH-1:0] wdata0,
  input  logic [WIDTH-1:0] wdata1,
  output logic             room,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH-1:0] mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  // Room for the worst case of two results, judged on the registered fill only.
  assign room     = (count <= CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= wdata0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + 1'b1] <= wdata1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push_count) - CNT_W'(pop);
    end
  end

endmodule

>>> src/source_token_scanner_top.sv
// Top level of the source token scanner: input register, scan core and result queue.
// Path: input register, then scan core, whose results are written into the result queue.
// Throughput: one byte per cycle; the input stalls only while the result queue holds more
// than two beats, which only happens when the sink stalls.
// Reset: synchronous and active high; clears position, scan state, pending token and queue,
// holds the input ready low, and bytes are taken from the first cycle after release.
module source_token_scanner_top import stsc_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  stsc_byte_if.sink    in,
  stsc_token_if.source out
);

  // Packed result: kind, start, length, precedence, statement last, source end, run last.
  localparam int RES_W      = POSITION_BITS + LENGTH_BITS + 9;
  localparam int OFF_LENGTH = 5;
  localparam int OFF_START  = OFF_LENGTH + LENGTH_BITS;
  localparam int OFF_KIND   = OFF_START + POSITION_BITS;

  // Input register: one byte waits here while the core decides on it.
  logic             ir_valid;
  logic [7:0]       ir_byte;
  logic             room;
  logic             take;
  logic [1:0]       push_count;
  logic [RES_W-1:0] slot0, slot1;
  logic [RES_W-1:0] head;

  // The core takes the registered byte only when the queue can hold both possible
  // results; the input register reloads in the same cycle, so bytes stream at one a clock.
  // No byte is taken while reset is held.
  assign take     = ir_valid && room;
  assign in.ready = !rst && (!ir_valid || room);

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in.ready) begin
      ir_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      ir_byte <= in.source_byte;
    end
  end

  // Scan core: classifies the byte against the current scan and the pending token.
  stsc_scan_core #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .source_byte (ir_byte),
    .push_count  (push_count),
    .slot0       (slot0),
    .slot1       (slot1)
  );

  // Result queue: separates the sink's stalls from the byte stream.
  stsc_result_fifo #(
    .WIDTH (RES_W)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .wdata0     (slot0),
    .wdata1     (slot1),
    .room       (room),
    .rd_valid   (out.valid),
    .rd_ready   (out.ready),
    .rd_data    (head)
  );

  assign out.token_kind     = head[OFF_KIND +: 4];
  assign out.token_start    = head[OFF_START +: POSITION_BITS];
  assign out.token_length   = head[OFF_LENGTH +: LENGTH_BITS];
  assign out.op_precedence  = head[4:3];
  assign out.statement_last = head[2];
  assign out.source_end     = head[1];
  assign out.run_last       = head[0];

endmodule

>>> src/stsc_checker.sv
// Port-level checks of the source token scanner and their binding to the top level.
module stsc_checker import stsc_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [3:0]               token_kind,
  input logic [POSITION_BITS-1:0] token_start,
  input logic [LENGTH_BITS-1:0]   token_length,
  input logic [1:0]               op_precedence,
  input logic                     statement_last,
  input logic                     source_end,
  input logic                     run_last
);

  // A stalled beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(token_start)
      && $stable(token_length) && $stable(op_precedence) && $stable(statement_last)
      && $stable(source_end) && $stable(run_last))
    else $error("stalled result beat changed");

  // The end marker is an empty token that closes its byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && source_end |-> token_kind == K_NONE && token_length == '0
      && op_precedence == 2'd0 && !statement_last && run_last)
    else $error("malformed end marker");

  // Nothing follows the end marker.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && source_end |=> !out_valid)
    else $error("result after end of source");

  // Only operators carry a precedence.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && op_precedence != 2'd0 |-> token_kind == K_OPERATOR)
    else $error("precedence on a non-operator");

  // A segment always ends its statement and is the only result of its colon.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == K_SEGMENT |-> statement_last && run_last && !source_end)
    else $error("segment not closing its statement");

endmodule

bind source_token_scanner_top stsc_checker #(
  .POSITION_BITS (POSITION_BITS),
  .LENGTH_BITS   (LENGTH_BITS)
) u_stsc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out.valid),
  .out_ready      (out.ready),
  .token_kind     (out.token_kind),
  .token_start    (out.token_start),
  .token_length   (out.token_length),
  .op_precedence  (out.op_precedence),
  .statement_last (out.statement_last),
  .source_end     (out.source_end),
  .run_last       (out.run_last)
);

>>> tb/sv/source_token_scanner_top_tb.sv
// Self-checking testbench for the source token scanner, with its own token predictor.
`timescale 1ns / 1ps

module source_token_scanner_top_tb;
  import stsc_pkg::*;

  localparam int PB = POSITION_BITS_DEF;
  localparam int LB = LENGTH_BITS_DEF;
  localparam int DIRECTED_ROWS = 27;
  localparam int RANDOM_PER_PHASE = 35;
  localparam int DRAIN_CYCLES = 16;

  // One token beat as the block presents it.
  typedef struct packed {
    token_kind_t   kind;
    logic [PB-1:0] start;
    logic [LB-1:0] length;
    logic [1:0]    prec;
    logic          stmt_last;
    logic          src_end;
    logic          run_last;
  } token_t;

  // Everything the scanner remembers between bytes. The first three characters of a
  // name are kept in head, first character at index zero, for type word and keyword
  // matching.
  typedef struct packed {
    logic [PB-1:0]  pos;
    scan_mode_t     mode;
    logic [PB-1:0]  scan_start;
    logic [LB-1:0]  scan_len;
    logic [2:0][7:0] head;
    logic           held_valid;
    token_kind_t    held_kind;
    logic [PB-1:0]  held_start;
    logic [LB-1:0]  held_len;
    logic [1:0]     held_prec;
    logic           stmt_open;
    logic           done;
  } scanner_t;

  // A directed byte, with the single token it releases typed in where that token is
  // obvious; other rows are left to the predictor.
  typedef struct {
    logic [7:0] ch;
    bit         typed;
    token_t     want;
  } script_row_t;

  logic clk;
  logic rst;

  stsc_byte_if bytes_if ();
  stsc_token_if #(.POSITION_BITS(PB), .LENGTH_BITS(LB)) tokens_if ();

  source_token_scanner_top #(.POSITION_BITS(PB), .LENGTH_BITS(LB)) dut (
    .clk (clk),
    .rst (rst),
    .in  (bytes_if.sink),
    .out (tokens_if.source)
  );

  // The directed source. It walks through a type word, the two-letter prefix of ptr
  // (which must stay an identifier), every punctuation kind, precedence zero and two,
  // a byte with the top bit set, a carriage return, a stray colon, a statement closed
  // by a semicolon, a longer-than-keyword segment name, an exact keyword ended by a
  // tab and a number that runs straight into a name.
  script_row_t script [DIRECTED_ROWS] = '{
    '{"i",    1'b0, '0},
    '{"8",    1'b0, '0},
    '{" ",    1'b0, '0},
    '{"(",    1'b1, '{K_TYPE, PB'(0), LB'(2), 2'd0, 1'b0, 1'b0, 1'b1}},
    '{"p",    1'b0, '0},
    '{"t",    1'b0, '0},
    '{")",    1'b1, '{K_IDENT, PB'(4), LB'(2), 2'd0, 1'b0, 1'b0, 1'b1}},
    '{"9",    1'b0, '0},
    '{"*",    1'b0, '0},
    '{"=",    1'b1, '{K_OPERATOR, PB'(8), LB'(1), 2'd2, 1'b0, 1'b0, 1'b1}},
    '{",",    1'b0, '0},
    '{8'hFF,  1'b0, '0},
    '{8'h0D,  1'b0, '0},
    '{":",    1'b0, '0},
    '{";",    1'b1, '{K_UNKNOWN, PB'(13), LB'(1), 2'd0, 1'b1, 1'b0, 1'b1}},
    '{"r",    1'b0, '0},
    '{"e",    1'b0, '0},
    '{"t",    1'b0, '0},
    '{"x",    1'b0, '0},
    '{":",    1'b1, '{K_SEGMENT, PB'(15), LB'(4), 2'd0, 1'b1, 1'b0, 1'b1}},
    '{"e",    1'b0, '0},
    '{"n",    1'b0, '0},
    '{"d",    1'b0, '0},
    '{"\t",   1'b0, '0},
    '{"5",    1'b0, '0},
    '{"Z",    1'b0, '0},
    '{";",    1'b0, '0}
  };

  string type_words [9] = '{"i1", "i2", "i4", "i8", "u1", "u2", "u4", "u8", "ptr"};
  string keywords [2] = '{"ret", "end"};
  // Names that look like type words or keywords but are one character off.
  string near_words [10] = '{"pt", "ptrs", "i3", "u16", "i", "re", "endx", "u", "Ret", "I8"};
  string punct_chars = "(),=+-*/";
  string blank_chars = " \t\n";

  scanner_t scanner_state;  // advanced on every accepted beat, drives the checks
  scanner_t stream_state;   // advanced as bytes are chosen, steers the generator
  token_t   pending_tokens[$];

  int mismatch_count = 0;
  int bytes_taken = 0;
  int phase_bytes = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic token_t mk_token(token_kind_t kind, logic [PB-1:0] start,
                                      logic [LB-1:0] length, logic [1:0] prec,
                                      logic stmt_last, logic src_end);
    token_t t;
    t.kind = kind;
    t.start = start;
    t.length = length;
    t.prec = prec;
    t.stmt_last = stmt_last;
    t.src_end = src_end;
    t.run_last = 1'b0;
    return t;
  endfunction

  // Type words and keywords need the whole name to match, so only two- and
  // three-character names are candidates.
  function automatic token_kind_t word_kind(logic [2:0][7:0] head, logic [LB-1:0] n);
    token_kind_t k;
    k = K_IDENT;
    if (n == 2) begin
      case ({head[0], head[1]})
        "i1", "i2", "i4", "i8", "u1", "u2", "u4", "u8": k = K_TYPE;
        default: k = K_IDENT;
      endcase
    end else if (n == 3) begin
      case ({head[0], head[1], head[2]})
        "ptr": k = K_TYPE;
        "ret", "end": k = K_KEYWORD;
        default: k = K_IDENT;
      endcase
    end
    return k;
  endfunction

  function automatic void grow_scan(ref scanner_t s, input logic [7:0] c);
    if (s.scan_len < 3) s.head[s.scan_len[1:0]] = c;
    if (s.scan_len != {LB{1'b1}}) s.scan_len = s.scan_len + 1'b1;
  endfunction

  function automatic void close_scan(ref scanner_t s);
    s.held_kind = (s.mode == MODE_NAME) ? word_kind(s.head, s.scan_len) : K_INTEGER;
    s.held_start = s.scan_start;
    s.held_len = s.scan_len;
    s.held_prec = 2'd0;
    s.held_valid = 1'b1;
    s.mode = MODE_IDLE;
  endfunction

  function automatic void flush_held(ref scanner_t s, input logic stmt_last,
                                     ref token_t made[$]);
    if (s.held_valid) begin
      made.push_back(mk_token(s.held_kind, s.held_start, s.held_len, s.held_prec,
                              stmt_last, 1'b0));
      s.held_valid = 1'b0;
    end
  endfunction

  // Works out the tokens that one source byte releases and updates the state.
  function automatic void scan_byte(ref scanner_t s, input logic [7:0] c,
                                    ref token_t made[$]);
    logic [PB-1:0] at;
    logic letter;
    logic digit;
    token_kind_t kind;
    logic [1:0] prec;
    made = {};
    if (s.done) return;
    at = s.pos;
    s.pos = s.pos + 1'b1;
    letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    digit = (c >= "0" && c <= "9");

    if (s.mode == MODE_NAME) begin
      if (letter || digit) begin
        grow_scan(s, c);
        return;
      end
      if (c == CH_COLON) begin
        made.push_back(mk_token(K_SEGMENT, s.scan_start, s.scan_len, 2'd0, 1'b1, 1'b0));
        made[0].run_last = 1'b1;
        s.mode = MODE_IDLE;
        s.stmt_open = 1'b0;
        return;
      end
      close_scan(s);
    end else if (s.mode == MODE_NUMBER) begin
      if (digit) begin
        grow_scan(s, c);
        return;
      end
      close_scan(s);
    end

    if (c == CH_SPACE || c == CH_TAB || c == CH_LF) return;

    if (c == CH_NUL) begin
      flush_held(s, 1'b1, made);
      made.push_back(mk_token(K_NONE, at, '0, 2'd0, 1'b0, 1'b1));
      s.stmt_open = 1'b0;
      s.done = 1'b1;
    end else if (c == CH_SEMI) begin
      if (s.held_valid) begin
        flush_held(s, 1'b1, made);
      end else if (!s.stmt_open) begin
        made.push_back(mk_token(K_NONE, at, '0, 2'd0, 1'b0, 1'b1));
        s.done = 1'b1;
      end
      s.stmt_open = 1'b0;
    end else if (letter || digit) begin
      flush_held(s, 1'b0, made);
      s.mode = letter ? MODE_NAME : MODE_NUMBER;
      s.scan_start = at;
      s.scan_len = LB'(1);
      s.head = '0;
      s.head[0] = c;
      s.stmt_open = 1'b1;
    end else begin
      flush_held(s, 1'b0, made);
      prec = 2'd0;
      case (c)
        CH_LPAREN: kind = K_LPAREN;
        CH_RPAREN: kind = K_RPAREN;
        CH_COMMA:  kind = K_COMMA;
        CH_EQUAL:  kind = K_OPERATOR;
        CH_PLUS, CH_MINUS: begin
          kind = K_OPERATOR;
          prec = 2'd1;
        end
        CH_STAR, CH_SLASH: begin
          kind = K_OPERATOR;
          prec = 2'd2;
        end
        default: kind = K_UNKNOWN;
      endcase
      s.held_valid = 1'b1;
      s.held_kind = kind;
      s.held_start = at;
      s.held_len = LB'(1);
      s.held_prec = prec;
      s.stmt_open = 1'b1;
    end

    if (made.size() != 0) made[made.size() - 1].run_last = 1'b1;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and the receiving side
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The token sink stalls at random at the rate of the current phase. It is the only
  // process that drives ready, so ready gets one update per edge.
  initial begin
    tokens_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tokens_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Checker. Both handshakes are sampled right at the rising edge, before any
  // nonblocking update of that edge lands, so each sees what the block saw. A beat
  // that leaves the block at this edge can never stem from a byte taken at the same
  // edge, so the output side is handled first.
  always @(posedge clk) begin
    token_t got;
    token_t want;
    token_t made[$];
    if (!rst) begin
      if (tokens_if.valid && tokens_if.ready) begin
        got.kind = token_kind_t'(tokens_if.token_kind);
        got.start = tokens_if.token_start;
        got.length = tokens_if.token_length;
        got.prec = tokens_if.op_precedence;
        got.stmt_last = tokens_if.statement_last;
        got.src_end = tokens_if.source_end;
        got.run_last = tokens_if.run_last;
        if (pending_tokens.size() == 0) begin
          $error("token beat (kind %0d at %0d) arrived with no token pending",
                 got.kind, got.start);
          mismatch_count++;
        end else begin
          want = pending_tokens.pop_front();
          check_field("token_kind", 32'(want.kind), 32'(got.kind));
          check_field("token_start", 32'(want.start), 32'(got.start));
          check_field("token_length", 32'(want.length), 32'(got.length));
          check_field("op_precedence", 32'(want.prec), 32'(got.prec));
          check_field("statement_last", 32'(want.stmt_last), 32'(got.stmt_last));
          check_field("source_end", 32'(want.src_end), 32'(got.src_end));
          check_field("run_last", 32'(want.run_last), 32'(got.run_last));
        end
      end
      if (bytes_if.valid && bytes_if.ready) begin
        scan_byte(scanner_state, bytes_if.source_byte, made);
        // Typed-in rows of the directed source replace the predicted token, so that
        // those rows do not lean on the predictor at all.
        if (bytes_taken < DIRECTED_ROWS && script[bytes_taken].typed) begin
          made = {script[bytes_taken].want};
        end
        foreach (made[i]) pending_tokens.push_back(made[i]);
        bytes_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Source byte generation
  // ---------------------------------------------------------------------------

  // Offers one beat, after a random number of idle cycles, and returns at the edge
  // that accepts it. Valid stays high from one beat to the next when no idle cycle
  // falls between them.
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      bytes_if.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_if.valid <= 1'b1;
    bytes_if.source_byte <= c;
    @(posedge clk);
    while (!bytes_if.ready) @(posedge clk);
  endtask

  task automatic put_char(input logic [7:0] c);
    token_t dropped[$];
    scan_byte(stream_state, c, dropped);
    send_byte(c);
    phase_bytes++;
  endtask

  task automatic put_word(input string w);
    for (int i = 0; i < w.len(); i++) put_char(w[i]);
  endtask

  // A semicolon that would find an empty statement ends the source for good, and reset
  // is never applied again, so the generator only sends one that closes something.
  function automatic bit semi_safe();
    return stream_state.mode != MODE_IDLE || stream_state.held_valid || stream_state.stmt_open;
  endfunction

  function automatic logic [7:0] random_letter();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] random_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  task automatic random_name(input int lo, input int hi);
    int n;
    n = $urandom_range(hi, lo);
    put_char(random_letter());
    repeat (n - 1) put_char(($urandom_range(3) == 0) ? random_digit() : random_letter());
  endtask

  task automatic random_number(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) put_char(random_digit());
  endtask

  // Half the time nothing, otherwise one or two of space, tab and newline.
  task automatic random_blank();
    if ($urandom_range(1)) begin
      repeat ($urandom_range(2, 1)) put_char(blank_chars[$urandom_range(2)]);
    end
  endtask

  task automatic random_token();
    case ($urandom_range(9))
      0, 1: random_name(1, 8);
      2: put_word(type_words[$urandom_range(8)]);
      3: put_word(keywords[$urandom_range(1)]);
      4: put_word(near_words[$urandom_range(9)]);
      5: random_number(1, 5);
      6: begin
        // A number running straight into a name splits into two tokens.
        random_number(1, 3);
        random_name(1, 3);
      end
      default: put_char(punct_chars[$urandom_range(7)]);
    endcase
  endtask

  // A statement: sometimes a segment label first, then a few tokens with random
  // blanks, usually closed by a semicolon.
  task automatic random_statement();
    if ($urandom_range(4) == 0) begin
      random_name(1, 6);
      put_char(CH_COLON);
      random_blank();
    end
    repeat ($urandom_range(6, 1)) begin
      random_token();
      random_blank();
    end
    if ($urandom_range(9) != 0 && semi_safe()) put_char(CH_SEMI);
  endtask

  // Arbitrary nonzero bytes: stray colons, carriage returns, bytes above 0x7F and
  // anything else. A semicolon that would end the source becomes a space.
  task automatic random_noise();
    logic [7:0] c;
    repeat ($urandom_range(4, 1)) begin
      c = 8'($urandom_range(255, 1));
      if (c == CH_SEMI && !semi_safe()) c = CH_SPACE;
      put_char(c);
    end
  endtask

  // Holds the sender off until every predicted token has come out. The first edge
  // lets the checker record the last accepted byte before the queue is looked at.
  task automatic drain_tokens();
    bytes_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst <= 1'b1;
    bytes_if.valid <= 1'b0;
    bytes_if.source_byte <= '0;
    scanner_state = '0;
    stream_state = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 15;
    recv_idle_pct = 79;
    foreach (script[i]) put_char(script[i].ch);

    // Three phases: a sender that rarely idles against a sink that mostly stalls, then
    // the reverse, then both at full rate. Each phase ends with the sender waiting for
    // the token queue to run dry.
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 15 : (p == 1) ? 79 : 0;
      recv_idle_pct = (p == 0) ? 79 : (p == 1) ? 15 : 0;
      if (p == 2) begin
        // A name just long enough to saturate the length field.
        put_char(random_letter());
        repeat (255) put_char(($urandom_range(1) == 0) ? random_digit() : random_letter());
        put_char(CH_SEMI);
      end
      phase_bytes = 0;
      while (phase_bytes < RANDOM_PER_PHASE) begin
        if ($urandom_range(9) < 8) begin
          random_statement();
        end else begin
          random_noise();
        end
      end
      drain_tokens();
    end

    // A zero byte behind a pending name flushes it and marks the end of the source,
    // the one byte that yields two beats. Everything after it must be ignored.
    put_char("x");
    put_char(CH_NUL);
    put_char(CH_SEMI);
    put_char("a");
    put_char(CH_NUL);
    put_char(8'hFF);
    drain_tokens();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
src/stsc_pkg.sv
src/stsc_if.sv
src/stsc_scan_core.sv
src/stsc_result_fifo.sv
src/source_token_scanner_top.sv
src/stsc_checker.sv
tb/sv/source_token_scanner_top_tb.sv
